// ----- sv/lidar_emergency_brake_check_defines.svh -----
`ifndef LIDAR_EMERGENCY_BRAKE_CHECK_DEFINES_SVH
`define LIDAR_EMERGENCY_BRAKE_CHECK_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LEBC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LEBC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/lebc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lebc_pkg;

   localparam int unsigned NUM_WIN = 4;

   // distance 0..65535 mm, radius 0 means no return
   localparam logic [15:0] NO_RETURN = 16'hFFFF;
   localparam logic [15:0] FAR_LIMIT = 16'd20000;

   // forward windows in 1/16 degree: inside when angle <= low or angle >= high
   localparam logic [12:0] WIN_LOW  [NUM_WIN] = '{13'd720, 13'd480, 13'd320, 13'd240};
   localparam logic [12:0] WIN_HIGH [NUM_WIN] = '{13'd5040, 13'd5280, 13'd5440, 13'd5520};

   // speed thresholds, Q8.8
   localparam logic signed [15:0] BAND1_SPEED = 16'sd5120;
   localparam logic signed [15:0] BAND2_SPEED = 16'sd6400;
   localparam logic signed [15:0] BAND3_SPEED = 16'sd7680;
   localparam logic signed [15:0] SLOW_SPEED  = 16'sd4096;
   localparam logic signed [15:0] MID_SPEED   = 16'sd4864;
   localparam logic signed [15:0] FAST_SPEED  = 16'sd8960;
   localparam logic signed [15:0] REVERSE_SPEED = -16'sd3;

   localparam logic [15:0] SLOW_DIST = 16'd200;
   localparam logic [15:0] MID_DIST  = 16'd400;
   localparam logic [15:0] FAST_DIST = 16'd1500;

   // register indexes
   localparam logic [2:0] CSR_FLEXIBLE_MODE   = 3'd0;
   localparam logic [2:0] CSR_FIXED_DISTANCE  = 3'd1;
   localparam logic [2:0] CSR_SQUARE_COEF     = 3'd2;
   localparam logic [2:0] CSR_LINEAR_COEF     = 3'd3;
   localparam logic [2:0] CSR_DISTANCE_OFFSET = 3'd4;

   localparam logic OP_SCAN_POINT = 1'b0;
   localparam logic OP_SPEED      = 1'b1;

   typedef struct packed {
      logic              operation;
      logic              scan_start;
      logic [12:0]       point_angle;
      logic [15:0]       point_radius;
      logic signed [15:0] speed_value;
      logic [31:0]       stamp;
   } lebc_req_type;

   typedef struct packed {
      logic signed [15:0] pass_speed;
      logic              brake;
      logic [31:0]       stamp_out;
   } lebc_rsp_type;

   typedef struct packed {
      logic update_scan;
      logic capture_sample;
      logic load_result;
   } lebc_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SQR  = 4'b0010,
      ST_PROD = 4'b0100,
      ST_EVAL = 4'b1000
   } lebc_state_type;

endpackage

`default_nettype wire

// ----- sv/lebc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "lidar_emergency_brake_check_defines.svh"

module lebc_ctrl
   import lebc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_operation,
   output logic              req_stall,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output lebc_cmd_type      cmd
);

   lebc_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           req_take;
   logic           slot_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_operation == OP_SPEED) begin
                  cmd.capture_sample = 1'b1;
                  state_in = ST_SQR;
               end else begin
                  cmd.update_scan = 1'b1;
               end
            end
         end
         ST_SQR:  state_in = ST_PROD;
         ST_PROD: state_in = ST_EVAL;
         ST_EVAL: begin
            // hold until the output register can take the result
            if (slot_free) begin
               cmd.load_result = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `LEBC_ASSERT_NEXT(a_sample_starts, req_take && (req_operation == OP_SPEED),
      state_ff == ST_SQR, "speed sample did not start evaluation")
   `LEBC_ASSERT_NEXT(a_sqr_to_prod, state_ff == ST_SQR, state_ff == ST_PROD,
      "multiply stage skipped")
   `LEBC_ASSERT_NEXT(a_eval_waits, (state_ff == ST_EVAL) && rsp_valid_ff && rsp_stall,
      state_ff == ST_EVAL, "result would overwrite a waiting one")
   `LEBC_ASSERT_NEXT(a_load_shows, cmd.load_result, rsp_valid_ff,
      "loaded result not presented")

endmodule

`default_nettype wire

// ----- sv/lebc_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lebc_datapath
   import lebc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire lebc_cmd_type cmd,
   input  wire lebc_req_type req_data,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [15:0]  csr_wdata,
   output lebc_rsp_type      rsp_data
);

   // configuration
   logic               flexible_mode_ff;
   logic [15:0]        fixed_distance_ff;
   logic signed [15:0] square_coef_ff;
   logic signed [15:0] linear_coef_ff;
   logic signed [15:0] distance_offset_ff;

   // window minima and brake state
   logic [15:0] win_min_ff [NUM_WIN];
   logic [15:0] win_min_in [NUM_WIN];
   logic        brake_ff, brake_in;

   // captured sample and arithmetic pipeline
   logic signed [15:0] spd_ff;
   logic [31:0]        stamp_ff;
   logic [13:0]        spd_mag;
   logic [27:0]        sq_ff, sq_in;
   logic signed [30:0] lin_s_ff, lin_s_in;
   logic signed [44:0] prod_ff, prod_in;
   logic signed [44:0] base_ff, base_in;
   logic signed [45:0] dist_sum;
   logic signed [45:0] min_scaled;

   lebc_rsp_type rsp_ff, rsp_in;
   logic [15:0]  sel_min;
   logic         near;

   always_ff @(posedge clock) begin
      if (reset) begin
         flexible_mode_ff   <= 1'b1;
         fixed_distance_ff  <= 16'd500;
         square_coef_ff     <= '0;
         linear_coef_ff     <= '0;
         distance_offset_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FLEXIBLE_MODE:   flexible_mode_ff   <= csr_wdata[0];
            CSR_FIXED_DISTANCE:  fixed_distance_ff  <= csr_wdata;
            CSR_SQUARE_COEF:     square_coef_ff     <= csr_wdata;
            CSR_LINEAR_COEF:     linear_coef_ff     <= csr_wdata;
            CSR_DISTANCE_OFFSET: distance_offset_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // scan point: restart on scan start, then fold in a nonzero radius
   always_comb begin
      logic [15:0] start_val;
      for (int i = 0; i < NUM_WIN; i++) begin
         start_val = req_data.scan_start ? NO_RETURN : win_min_ff[i];
         win_min_in[i] = start_val;
         if ((req_data.point_radius != '0) &&
             ((req_data.point_angle <= WIN_LOW[i]) || (req_data.point_angle >= WIN_HIGH[i])) &&
             (req_data.point_radius < start_val)) begin
            win_min_in[i] = req_data.point_radius;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_WIN; i++) begin
            win_min_ff[i] <= NO_RETURN;
         end
      end else if (cmd.update_scan) begin
         for (int i = 0; i < NUM_WIN; i++) begin
            win_min_ff[i] <= win_min_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture_sample) begin
         spd_ff   <= req_data.speed_value;
         stamp_ff <= req_data.stamp;
      end
   end

   // speed is below 2^14 in the quadratic band, so 14 magnitude bits suffice
   assign spd_mag = spd_ff[13:0];

   always_comb begin
      sq_in    = {14'b0, spd_mag} * {14'b0, spd_mag};
      lin_s_in = {{15{linear_coef_ff[15]}}, linear_coef_ff} * $signed({17'b0, spd_mag});
      prod_in  = {{29{square_coef_ff[15]}}, square_coef_ff} * $signed({17'b0, sq_ff});
      base_in  = {{6{lin_s_ff[30]}}, lin_s_ff, 8'b0}
               + {{5{distance_offset_ff[15]}}, distance_offset_ff, 24'b0};
   end

   always_ff @(posedge clock) begin
      sq_ff    <= sq_in;
      lin_s_ff <= lin_s_in;
      prod_ff  <= prod_in;
      base_ff  <= base_in;
   end

   // distance in Q.24; radius < ceil(d) is radius * 2^24 < d, and the
   // saturated case only differs at radius 65535, which brakes anyway
   assign dist_sum   = {prod_ff[44], prod_ff} + {base_ff[44], base_ff};
   assign min_scaled = $signed({6'b0, sel_min, 24'b0});

   always_comb begin
      if (spd_ff < BAND1_SPEED) begin
         sel_min = win_min_ff[0];
      end else if (spd_ff < BAND2_SPEED) begin
         sel_min = win_min_ff[1];
      end else if (spd_ff < BAND3_SPEED) begin
         sel_min = win_min_ff[2];
      end else begin
         sel_min = win_min_ff[3];
      end

      if (!flexible_mode_ff) begin
         near = sel_min < fixed_distance_ff;
      end else if (spd_ff < SLOW_SPEED) begin
         near = sel_min < SLOW_DIST;
      end else if (spd_ff < MID_SPEED) begin
         near = sel_min < MID_DIST;
      end else if (spd_ff >= FAST_SPEED) begin
         near = sel_min < FAST_DIST;
      end else begin
         near = dist_sum > min_scaled;
      end

      brake_in = brake_ff;
      if (!spd_ff[15]) begin
         brake_in = near || (sel_min > FAR_LIMIT);
      end else if (spd_ff <= REVERSE_SPEED) begin
         brake_in = 1'b0;
      end

      rsp_in.pass_speed = brake_in ? '0 : spd_ff;
      rsp_in.brake      = brake_in;
      rsp_in.stamp_out  = stamp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brake_ff <= 1'b0;
      end else if (cmd.load_result) begin
         brake_ff <= brake_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// ----- sv/lidar_emergency_brake_check.sv -----
// Scan point: the window minima update at the edge that takes the transfer.
// Speed sample: captured at the transfer, then squared, multiplied and compared in
// the two-step multiply pipeline (SQR, PROD, EVAL) before the output register loads.
// Throughput: one scan point per cycle while no speed sample is in flight; a speed
// sample stalls the input until loaded, longer while a waiting result is stalled.
// Reset (synchronous, active high): minima to 65535, brake clear, registers to defaults.
`timescale 1ns / 1ps
`default_nettype none

module lidar_emergency_brake_check
   import lebc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // input channel
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire lebc_req_type req_data,
   // result channel
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output lebc_rsp_type      rsp_data,
   // register writes
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [15:0]  csr_wdata
);

   lebc_cmd_type cmd;

   // Sequencer: takes a transfer only when idle, walks a speed sample through
   // the multiply stages and waits in the last one for a free output slot.
   lebc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_data.operation),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd)
   );

   // Datapath: registers, window minima, braking distance arithmetic,
   // brake flag and the output register.
   lebc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- tb/lidar_emergency_brake_check_test.sv -----
`timescale 1ns / 1ps

module lidar_emergency_brake_check_test
   import lebc_pkg::*;
();

   // Forward windows in 1/16 degree: a point is inside when angle <= low or >= high.
   localparam logic [12:0] FWD_EDGE_LOW  [4] = '{13'd720, 13'd480, 13'd320, 13'd240};
   localparam logic [12:0] FWD_EDGE_HIGH [4] = '{13'd5040, 13'd5280, 13'd5440, 13'd5520};

   // Speed band edges, Q8.8
   localparam logic signed [15:0] SPEED_BAND_1  = 16'sd5120;   // 20 m/s
   localparam logic signed [15:0] SPEED_BAND_2  = 16'sd6400;   // 25 m/s
   localparam logic signed [15:0] SPEED_BAND_3  = 16'sd7680;   // 30 m/s
   localparam logic signed [15:0] SPEED_SLOW    = 16'sd4096;   // 16 m/s
   localparam logic signed [15:0] SPEED_MID     = 16'sd4864;   // 19 m/s
   localparam logic signed [15:0] SPEED_FAST    = 16'sd8960;   // 35 m/s
   localparam logic signed [15:0] REVERSE_LIMIT = -16'sd3;     // below -0.01 m/s

   localparam logic [15:0] DIST_SLOW    = 16'd200;
   localparam logic [15:0] DIST_MID     = 16'd400;
   localparam logic [15:0] DIST_FAST    = 16'd1500;
   localparam logic [15:0] FAR_LIMIT_MM = 16'd20000;
   localparam logic [15:0] EMPTY_MM     = 16'hFFFF;

   localparam logic [12:0] ANGLE_EDGES [18] = '{
      13'd0, 13'd240, 13'd241, 13'd320, 13'd321, 13'd480, 13'd481, 13'd720, 13'd721,
      13'd5039, 13'd5040, 13'd5279, 13'd5280, 13'd5439, 13'd5440, 13'd5519, 13'd5520,
      13'd5759};
   localparam logic [15:0] SPEED_EDGES [20] = '{
      16'h0000, 16'hFFFF, 16'hFFFE, 16'hFFFD, 16'h8000, 16'h7FFF, 16'd4095, 16'd4096,
      16'd4863, 16'd4864, 16'd5119, 16'd5120, 16'd6399, 16'd6400, 16'd7679, 16'd7680,
      16'd8959, 16'd8960, 16'd1, 16'hFFFC};

   localparam int unsigned WATCHDOG_LIMIT = 3000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   lebc_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   lebc_rsp_type rsp_data;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [15:0]  csr_wdata = '0;

   // Predictor copy of the register file
   logic              flex_mode   = 1'b1;
   logic [15:0]       fixed_dist  = 16'd500;
   logic signed [15:0] sq_coef    = '0;
   logic signed [15:0] lin_coef   = '0;
   logic signed [15:0] dist_offset = '0;

   // Predictor copy of the block state
   logic [15:0] nearest_mm [4] = '{EMPTY_MM, EMPTY_MM, EMPTY_MM, EMPTY_MM};
   logic        brake_state = 1'b0;

   lebc_req_type outgoing_samples [$];
   lebc_rsp_type expected_commands [$];

   int unsigned send_idle_pct = 26;
   int unsigned recv_stall_pct = 70;
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles = 0;

   lidar_emergency_brake_check i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Append one item to the driver's queue.
   function automatic void add_item(input lebc_req_type it);
      outgoing_samples = {outgoing_samples, it};
   endfunction

   // Braking distance in whole mm for a forward speed, as the flexible or
   // fixed rule gives it. The quadratic term is kept exact in Q.24 and
   // rounded up before saturation.
   function automatic logic [15:0] stopping_distance(input logic signed [15:0] s);
      longint acc;
      if (!flex_mode) return fixed_dist;
      if (s < SPEED_SLOW) return DIST_SLOW;
      if (s < SPEED_MID) return DIST_MID;
      if (s >= SPEED_FAST) return DIST_FAST;
      // speed is positive in this band, so |s| = s
      acc = longint'(sq_coef) * longint'(s) * longint'(s)
          + longint'(lin_coef) * longint'(s) * 64'sd256
          + longint'(dist_offset) * 64'sd16777216;
      if (acc <= 0) return 16'd0;
      acc = (acc + 64'sd16777215) / 64'sd16777216;
      if (acc > 64'sd65535) return 16'hFFFF;
      return 16'(acc);
   endfunction

   // Advance the predicted state by one accepted transfer; a speed sample
   // queues the speed command it must produce.
   function automatic void apply_lidar_item(input lebc_req_type it);
      lebc_rsp_type       cmd;
      logic signed [15:0] s;
      logic [15:0]        m;
      if (it.operation == OP_SCAN_POINT) begin
         if (it.scan_start) begin
            for (int i = 0; i < 4; i++) nearest_mm[i] = EMPTY_MM;
         end
         // a zero radius is no return and never counts as an obstacle
         if (it.point_radius != 16'd0) begin
            for (int i = 0; i < 4; i++) begin
               if ((it.point_angle <= FWD_EDGE_LOW[i] || it.point_angle >= FWD_EDGE_HIGH[i])
                   && it.point_radius < nearest_mm[i])
                  nearest_mm[i] = it.point_radius;
            end
         end
      end else begin
         s = it.speed_value;
         if (s >= 16'sd0) begin
            if (s < SPEED_BAND_1) m = nearest_mm[0];
            else if (s < SPEED_BAND_2) m = nearest_mm[1];
            else if (s < SPEED_BAND_3) m = nearest_mm[2];
            else m = nearest_mm[3];
            // an empty window reads 65535 and so always brakes
            brake_state = (m < stopping_distance(s)) || (m > FAR_LIMIT_MM);
         end else if (s <= REVERSE_LIMIT) begin
            brake_state = 1'b0;
         end
         // a slight reverse speed keeps the previous decision
         cmd.pass_speed = brake_state ? 16'sd0 : s;
         cmd.brake      = brake_state;
         cmd.stamp_out  = it.stamp;
         expected_commands = {expected_commands, cmd};
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // Driver: offer the next queued item whenever the channel is free, with
   // random idle cycles. Predict at the edge that takes the transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) apply_lidar_item(req_data);
         if (!req_valid || !req_stall) begin
            if (outgoing_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= outgoing_samples.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each speed command against the oldest prediction and
   // stall the result channel at random.
   always @(posedge clock) begin
      lebc_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_commands.size() == 0) begin
               report_mismatch($sformatf("unexpected result, stamp %h", rsp_data.stamp_out));
            end else begin
               want = expected_commands.pop_front();
               if (rsp_data.pass_speed !== want.pass_speed)
                  report_mismatch($sformatf("pass_speed %0d, want %0d (stamp %h)",
                     rsp_data.pass_speed, want.pass_speed, want.stamp_out));
               if (rsp_data.brake !== want.brake)
                  report_mismatch($sformatf("brake %b, want %b (stamp %h)",
                     rsp_data.brake, want.brake, want.stamp_out));
               if (rsp_data.stamp_out !== want.stamp_out)
                  report_mismatch($sformatf("stamp_out %h, want %h",
                     rsp_data.stamp_out, want.stamp_out));
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Watchdog: drop the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic lebc_req_type make_item(input logic op, input logic start,
         input logic [12:0] angle, input logic [15:0] radius, input logic [15:0] speed);
      lebc_req_type it;
      it.operation    = op;
      it.scan_start   = start;
      it.point_angle  = angle;
      it.point_radius = radius;
      it.speed_value  = speed;
      it.stamp        = $urandom;
      return it;
   endfunction

   // Angles cluster on the window edges; a few lie past 360 degrees.
   function automatic logic [12:0] pick_angle();
      case ($urandom_range(9))
         0, 1, 2: return ANGLE_EDGES[$urandom_range(17)];
         3:       return 13'($urandom_range(8191, 5760));
         4, 5:    return 13'($urandom_range(5759));
         6, 7:    return 13'($urandom_range(720));
         default: return 13'($urandom_range(5759, 5040));
      endcase
   endfunction

   function automatic logic [15:0] pick_radius();
      case ($urandom_range(9))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(20010, 19990));
         3:       return 16'($urandom_range(16'hFFFF));
         default: return 16'($urandom_range(3000, 1));
      endcase
   endfunction

   function automatic logic [15:0] pick_speed();
      case ($urandom_range(9))
         0:       return SPEED_EDGES[$urandom_range(19)];
         1:       return 16'(-int'($urandom_range(2, 1)));
         2:       return 16'(-int'($urandom_range(32768, 3)));
         3:       return 16'($urandom_range(4095));
         4:       return 16'($urandom_range(4863, 4096));
         5, 6:    return 16'($urandom_range(8959, 4864));
         7:       return 16'($urandom_range(32767, 8960));
         8:       return 16'($urandom_range(16'hFFFF));
         default: return 16'($urandom_range(8959, 5120));
      endcase
   endfunction

   // Mostly whole scans (start point, points, then speed samples); the rest
   // is loose items with every field random.
   task automatic queue_random_items(input int unsigned count);
      int unsigned made;
      int unsigned points;
      int unsigned samples;
      made = 0;
      while (made < count) begin
         if ($urandom_range(99) < 85) begin
            points  = $urandom_range(30, 3);
            samples = $urandom_range(4, 1);
            // leave the start off now and then so minima carry across scans
            add_item(make_item(OP_SCAN_POINT, $urandom_range(99) < 85,
               pick_angle(), pick_radius(), 16'($urandom)));
            repeat (points)
               add_item(make_item(OP_SCAN_POINT, 1'b0,
                  pick_angle(), pick_radius(), 16'($urandom)));
            repeat (samples)
               add_item(make_item(OP_SPEED, 1'($urandom),
                  13'($urandom), 16'($urandom), pick_speed()));
            made += 1 + points + samples;
         end else begin
            add_item(make_item(1'($urandom), 1'($urandom),
               13'($urandom), 16'($urandom), 16'($urandom)));
            made++;
         end
      end
   endtask

   // Hold until nothing is queued, offered or outstanding.
   task automatic wait_drained();
      do @(posedge clock);
      while (outgoing_samples.size() != 0 || req_valid || expected_commands.size() != 0);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_FLEXIBLE_MODE:   flex_mode   = value[0];
         CSR_FIXED_DISTANCE:  fixed_dist  = value;
         CSR_SQUARE_COEF:     sq_coef     = value;
         CSR_LINEAR_COEF:     lin_coef    = value;
         CSR_DISTANCE_OFFSET: dist_offset = value;
         default: ;
      endcase
   endtask

   // Drain, let the block settle, then rewrite every register and the idling.
   task automatic reprogram(input logic flex, input logic [15:0] fixed_mm,
         input logic [15:0] sq, input logic [15:0] lin, input logic [15:0] offs,
         input int unsigned send_pct, input int unsigned recv_pct);
      wait_drained();
      repeat (8) @(posedge clock);
      write_reg(CSR_FLEXIBLE_MODE, {15'd0, flex});
      write_reg(CSR_FIXED_DISTANCE, fixed_mm);
      write_reg(CSR_SQUARE_COEF, sq);
      write_reg(CSR_LINEAR_COEF, lin);
      write_reg(CSR_DISTANCE_OFFSET, offs);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   initial begin
      int unsigned phase;
      int unsigned send_pct;
      int unsigned recv_pct;
      logic        flex;
      logic [15:0] fixed_mm;
      logic [15:0] sq;
      logic [15:0] lin;
      logic [15:0] offs;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed checks at the reset register values (flexible, zero coefficients).
      // empty windows brake; slight reverse keeps, real reverse clears
      add_item(make_item(OP_SPEED, 1'b0, 13'h1FFF, 16'hFFFF, 16'd0));
      add_item(make_item(OP_SPEED, 1'b0, 13'd0, 16'd0, 16'hFFFF));
      add_item(make_item(OP_SPEED, 1'b0, 13'd0, 16'd0, 16'hFFFD));
      add_item(make_item(OP_SPEED, 1'b0, 13'd0, 16'd0, 16'hFFFE));
      // start with no return, then the outer window edge and the inner one
      add_item(make_item(OP_SCAN_POINT, 1'b1, 13'd0, 16'd0, 16'h7FFF));
      add_item(make_item(OP_SCAN_POINT, 1'b0, 13'd720, 16'd150, 16'h8000));
      add_item(make_item(OP_SCAN_POINT, 1'b0, 13'd5520, 16'd20000, 16'd0));
      add_item(make_item(OP_SPEED, 1'b0, 13'd0, 16'd0, 16'd4095));
      add_item(make_item(OP_SPEED, 1'b0, 13'd0, 16'd0, 16'd5120));
      add_item(make_item(OP_SPEED, 1'b0, 13'd0, 16'd0, 16'h7FFF));
      // just past the far limit in every window
      add_item(make_item(OP_SCAN_POINT, 1'b1, 13'd5759, 16'd20001, 16'd0));
      add_item(make_item(OP_SPEED, 1'b0, 13'd0, 16'd0, 16'd8960));
      add_item(make_item(OP_SPEED, 1'b0, 13'd0, 16'd0, 16'h8000));
      // outside every window, then past 360 degrees (inside every window)
      add_item(make_item(OP_SCAN_POINT, 1'b0, 13'd4096, 16'd1, 16'd0));
      add_item(make_item(OP_SPEED, 1'b0, 13'd0, 16'd0, 16'd4864));
      add_item(make_item(OP_SCAN_POINT, 1'b0, 13'h1FFF, 16'd1, 16'd0));
      add_item(make_item(OP_SPEED, 1'b0, 13'd0, 16'd0, 16'd4864));
      // start flag on a speed sample does nothing
      add_item(make_item(OP_SPEED, 1'b1, 13'h1FFF, 16'hFFFF, 16'd7680));
      add_item(make_item(OP_SPEED, 1'b0, 13'd0, 16'd0, 16'd6400));
      add_item(make_item(OP_SPEED, 1'b0, 13'd0, 16'd0, 16'd8959));

      for (phase = 1; phase <= 7; phase++) begin
         // sender idles lightly first, then the receiver eases off, then no idling
         if (phase <= 2) begin
            send_pct = 26;
            recv_pct = 70;
         end else if (phase <= 5) begin
            send_pct = 70;
            recv_pct = 26;
         end else begin
            send_pct = 0;
            recv_pct = 0;
         end
         fixed_mm = 16'($urandom_range(3000, 100));
         sq       = 16'($urandom_range(600));
         lin      = 16'($urandom_range(4000)) - 16'd2000;
         offs     = 16'($urandom_range(2000)) - 16'd500;
         flex     = 1'b1;
         case (phase)
            2: begin
               fixed_mm = 16'hFFFF;
               sq       = 16'h7FFF;
               lin      = 16'h7FFF;
               offs     = 16'h7FFF;
            end
            3: begin
               fixed_mm = 16'd0;
               sq       = 16'h8000;
               lin      = 16'h8000;
               offs     = 16'h8000;
            end
            4: begin
               flex     = 1'b0;
               fixed_mm = 16'd0;
            end
            5: begin
               flex     = 1'b0;
               fixed_mm = 16'hFFFF;
            end
            6: flex = 1'b0;
            7: sq = 16'($urandom_range(1200)) - 16'd600;
            default: ;
         endcase
         reprogram(flex, fixed_mm, sq, lin, offs, send_pct, recv_pct);
         queue_random_items(135);
         // pause the sender until every command of the first half is back
         wait_drained();
         queue_random_items(135);
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
